// File: rtl/glbcc_pkg.sv
// Shared types and constants for the GLB container checker.
// Holds status codes, configuration indexes, reset values and the result record.
// No dependencies.
`timescale 1ns / 1ps

package glbcc_pkg;

    // Status reported on the last byte of an object
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_VERSION     = 3'd3,
        ST_LEN_MISM    = 3'd4,
        ST_ALIGN       = 3'd5,
        ST_ORDER       = 3'd6,
        ST_UNSUPPORTED = 3'd7
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_VERSION = 2'd0,
        CFG_JSON    = 2'd1,
        CFG_BINARY  = 2'd2
    } cfg_idx_t;

    localparam logic [31:0] VERSION_RST     = 32'd2;
    localparam logic [31:0] JSON_TYPE_RST   = 32'h4E4F_534A;
    localparam logic [31:0] BINARY_TYPE_RST = 32'h004E_4942;

    localparam logic [31:0] HEADER_BYTES = 32'd12;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] supported_version;
        logic [31:0] json_type_code;
        logic [31:0] binary_type_code;
    } cfg_t;

    typedef struct packed {
        logic        chunk_valid;
        logic [31:0] chunk_kind_word;
        logic [31:0] chunk_data_start;
        logic [31:0] chunk_size;
        logic        chunk_is_binary;
        logic        object_done;
        status_t     status_code;
    } result_t;

    // Expected magic "glTF", one byte per position
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0: m = 8'h67;
            2'd1: m = 8'h6C;
            2'd2: m = 8'h54;
            default: m = 8'h46;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/glb_container_checker.sv
// Top level of the GLB container checker: configuration, walker and result register.
// Depends on glbcc_pkg, glbcc_cfg, glbcc_walker and glbcc_out_reg.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+------------------------------------
//   s_        | in        | s_valid / s_ready    | data byte, last flag
//   m_        | out       | m_valid / m_ready    | chunk descriptor, done flag, status
//   cfg_      | in        | cfg_valid / cfg_ready| register index, write data
//
// One byte per cycle while s_ready is high; a result is in the result register in the cycle after its byte.
// Bytes that give no result still pass through the walker.
// s_ready is low only while the result register holds a request not yet taken.
// Synchronous active-low reset restores register defaults and clears object state.
// cfg_ready is always high; writes take effect on the next byte.
`timescale 1ns / 1ps

module glb_container_checker
    import glbcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_chunk_valid,
    output logic [31:0] m_chunk_kind_word,
    output logic [31:0] m_chunk_data_start,
    output logic [31:0] m_chunk_size,
    output logic        m_chunk_is_binary,
    output logic        m_object_done,
    output logic [2:0]  m_status_code,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t    cfg;
    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t res_q;
    logic    take_ok;

    assign cfg_ready = 1'b1;
    assign s_ready   = take_ok;
    assign in_fire   = s_valid && take_ok;

    glbcc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    glbcc_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    glbcc_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (in_fire && res_valid),
        .res_in  (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .take_ok (take_ok),
        .res_out (res_q)
    );

    assign m_chunk_valid      = res_q.chunk_valid;
    assign m_chunk_kind_word  = res_q.chunk_kind_word;
    assign m_chunk_data_start = res_q.chunk_data_start;
    assign m_chunk_size       = res_q.chunk_size;
    assign m_chunk_is_binary  = res_q.chunk_is_binary;
    assign m_object_done      = res_q.object_done;
    assign m_status_code      = res_q.status_code;

endmodule

// File: rtl/glbcc_cfg.sv
// Configuration registers of the GLB container checker.
// Depends on glbcc_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module glbcc_cfg
    import glbcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.supported_version <= VERSION_RST;
            cfg_reg.json_type_code    <= JSON_TYPE_RST;
            cfg_reg.binary_type_code  <= BINARY_TYPE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_VERSION: cfg_reg.supported_version <= cfg_data;
                CFG_JSON:    cfg_reg.json_type_code    <= cfg_data;
                CFG_BINARY:  cfg_reg.binary_type_code  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/glbcc_walker.sv
// Header check and chunk walk: per-object state updated once per accepted byte.
// Produces the result record for that byte. Depends on glbcc_pkg.
`timescale 1ns / 1ps

module glbcc_walker
    import glbcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_STOP   = 2'd2
    } phase_t;

    logic [31:0] byte_count_reg,      byte_count_next;
    logic [1:0]  lane_reg,            lane_next;
    logic        magic_good_reg,      magic_good_next;
    logic [31:0] header_version_reg,  header_version_next;
    logic [31:0] declared_length_reg, declared_length_next;
    phase_t      phase_reg,           phase_next;
    logic [31:0] pending_length_reg,  pending_length_next;
    logic [31:0] remaining_data_reg,  remaining_data_next;
    logic        seen_json_reg,       seen_json_next;
    logic        seen_binary_reg,     seen_binary_next;
    status_t     latched_error_reg,   latched_error_next;
    logic [2:0]  hdr_index_reg,       hdr_index_next;
    logic [31:0] type_word_reg,       type_word_next;

    logic [31:0] lane_bits;
    logic [32:0] total;
    logic        walk_en;
    logic        cv;
    logic        is_bin;
    status_t     chunk_err;
    status_t     status;

    assign lane_bits = {24'd0, data_byte} << {lane_reg, 3'b000};
    assign total     = {1'b0, byte_count_reg} + 33'd1;

    assign walk_en = (byte_count_reg >= HEADER_BYTES) && magic_good_reg &&
                     (header_version_reg == cfg.supported_version) &&
                     (latched_error_reg == ST_OK) && (phase_reg != PH_STOP) &&
                     (byte_count_reg < declared_length_reg);

    // Advance header capture and chunk walk for one byte
    always_comb begin
        byte_count_next      = byte_count_reg;
        lane_next            = lane_reg + 2'd1;
        magic_good_next      = magic_good_reg;
        header_version_next  = header_version_reg;
        declared_length_next = declared_length_reg;
        phase_next           = phase_reg;
        pending_length_next  = pending_length_reg;
        remaining_data_next  = remaining_data_reg;
        seen_json_next       = seen_json_reg;
        seen_binary_next     = seen_binary_reg;
        latched_error_next   = latched_error_reg;
        hdr_index_next       = hdr_index_reg;
        type_word_next       = type_word_reg;
        cv                   = 1'b0;
        is_bin               = 1'b0;
        chunk_err            = ST_OK;

        if (byte_count_reg < 32'd4) begin
            if (data_byte != magic_byte(byte_count_reg[1:0])) begin
                magic_good_next = 1'b0;
            end
        end else if (byte_count_reg < 32'd8) begin
            header_version_next = header_version_reg | lane_bits;
        end else if (byte_count_reg < HEADER_BYTES) begin
            declared_length_next = declared_length_reg | lane_bits;
        end else if (walk_en) begin
            if (phase_reg == PH_DATA) begin
                remaining_data_next = remaining_data_reg - 32'd1;
                if (remaining_data_reg == 32'd1) begin
                    phase_next     = PH_HEADER;
                    hdr_index_next = 3'd0;
                end
            end else if (hdr_index_reg == 3'd0 &&
                         ({1'b0, byte_count_reg} + 33'd8) > {1'b0, declared_length_reg}) begin
                // chunk header would run past the declared end
                latched_error_next = ST_SHORT;
                phase_next         = PH_STOP;
            end else begin
                // collect length word, then type word
                if (hdr_index_reg == 3'd0) begin
                    pending_length_next = lane_bits;
                    type_word_next      = 32'd0;
                end else if (!hdr_index_reg[2]) begin
                    pending_length_next = pending_length_reg | lane_bits;
                end else begin
                    type_word_next = type_word_reg | lane_bits;
                end
                hdr_index_next = hdr_index_reg + 3'd1;

                if (hdr_index_reg == 3'd7) begin
                    if (pending_length_reg[1:0] != 2'b00) begin
                        chunk_err = ST_ALIGN;
                    end else if (({1'b0, byte_count_reg} + 33'd1 + {1'b0, pending_length_reg})
                                 > {1'b0, declared_length_reg}) begin
                        chunk_err = ST_SHORT;
                    end else if (!seen_json_reg) begin
                        if (type_word_next != cfg.json_type_code) begin
                            chunk_err = ST_ORDER;
                        end else begin
                            seen_json_next = 1'b1;
                        end
                    end else if (type_word_next == cfg.binary_type_code && !seen_binary_reg) begin
                        seen_binary_next = 1'b1;
                        is_bin           = 1'b1;
                    end else begin
                        chunk_err = ST_UNSUPPORTED;
                    end

                    if (chunk_err != ST_OK) begin
                        latched_error_next = chunk_err;
                        phase_next         = PH_STOP;
                    end else begin
                        cv = 1'b1;
                        if (pending_length_reg != 32'd0) begin
                            phase_next          = PH_DATA;
                            remaining_data_next = pending_length_reg;
                        end
                    end
                end
            end
        end

        if (byte_count_reg != COUNT_MAX) begin
            byte_count_next = byte_count_reg + 32'd1;
        end
    end

    // Final status in the order of checks, from the state after this byte
    always_comb begin
        priority if (byte_count_reg < 32'd11) begin
            status = ST_SHORT;
        end else if (!magic_good_next) begin
            status = ST_BAD_MAGIC;
        end else if (header_version_next != cfg.supported_version) begin
            status = ST_VERSION;
        end else if (total != {1'b0, declared_length_next}) begin
            status = ST_LEN_MISM;
        end else if (latched_error_next != ST_OK) begin
            status = latched_error_next;
        end else if (!seen_json_next) begin
            status = ST_ORDER;
        end else begin
            status = ST_OK;
        end
    end

    // Build the result record; unused fields read as zero
    always_comb begin
        res_valid            = cv || last_byte;
        res.chunk_valid      = cv;
        res.chunk_kind_word  = cv ? type_word_next : 32'd0;
        res.chunk_data_start = cv ? total[31:0] : 32'd0;
        res.chunk_size       = cv ? pending_length_reg : 32'd0;
        res.chunk_is_binary  = cv && is_bin;
        res.object_done      = last_byte;
        res.status_code      = last_byte ? status : ST_OK;
    end

    // Hold object state; clear on reset and after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && last_byte)) begin
            byte_count_reg      <= 32'd0;
            lane_reg            <= 2'd0;
            magic_good_reg      <= 1'b1;
            header_version_reg  <= 32'd0;
            declared_length_reg <= 32'd0;
            phase_reg           <= PH_HEADER;
            pending_length_reg  <= 32'd0;
            remaining_data_reg  <= 32'd0;
            seen_json_reg       <= 1'b0;
            seen_binary_reg     <= 1'b0;
            latched_error_reg   <= ST_OK;
            hdr_index_reg       <= 3'd0;
            type_word_reg       <= 32'd0;
        end else if (in_fire) begin
            byte_count_reg      <= byte_count_next;
            lane_reg            <= lane_next;
            magic_good_reg      <= magic_good_next;
            header_version_reg  <= header_version_next;
            declared_length_reg <= declared_length_next;
            phase_reg           <= phase_next;
            pending_length_reg  <= pending_length_next;
            remaining_data_reg  <= remaining_data_next;
            seen_json_reg       <= seen_json_next;
            seen_binary_reg     <= seen_binary_next;
            latched_error_reg   <= latched_error_next;
            hdr_index_reg       <= hdr_index_next;
            type_word_reg       <= type_word_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_data_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> remaining_data_reg != 32'd0)
        else $error("data phase with no bytes remaining");

    a_hdr_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_index_reg != 3'd0 |-> phase_reg == PH_HEADER)
        else $error("chunk header index outside header phase");

    a_bin_after_json: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_binary_reg |-> seen_json_reg)
        else $error("binary chunk recorded without JSON chunk");

    a_err_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        latched_error_reg != ST_OK |-> phase_reg == PH_STOP)
        else $error("chunk error latched but walk not stopped");
`endif

endmodule

// File: rtl/glbcc_out_reg.sv
// Result register between the walker and the result channel.
// Depends on glbcc_pkg for result_t.
`timescale 1ns / 1ps

module glbcc_out_reg
    import glbcc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res_in,
    input  logic    m_ready,
    output logic    m_valid,
    output logic    take_ok,
    output result_t res_out
);

    logic    m_valid_reg, m_valid_next;
    result_t res_reg;

    // Slot is free when empty or drained this cycle
    assign take_ok = !m_valid_reg || m_ready;

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = m_valid_reg;
    assign res_out = res_reg;

endmodule

// File: dv/glb_container_checker_tb.sv
// Self-checking testbench for glb_container_checker: byte stream in, chunk reports out.
// Drives whole objects through valid/ready with random gaps and predicts each report.
// Depends on glbcc_pkg and the glb_container_checker RTL.
`timescale 1ns / 1ps

module glb_container_checker_tb;
    import glbcc_pkg::*;

    // "glTF" packed so that the low byte goes first on the wire
    localparam logic [31:0] GLB_MAGIC_LE = 32'h4654_6C67;

    typedef enum logic [1:0] {WALK_HEADER, WALK_DATA, WALK_STOP} walk_t;

    typedef enum int {
        OBJ_VALID, OBJ_BAD_MAGIC, OBJ_BAD_VERSION, OBJ_LEN_OFF, OBJ_MISALIGNED,
        OBJ_OVERRUN, OBJ_NOT_JSON, OBJ_BAD_SECOND, OBJ_TWO_BINARY, OBJ_HDR_ONLY,
        OBJ_CROSSING, OBJ_TRUNCATED, OBJ_TRAILING, OBJ_NOISE
    } shape_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_chunk_valid;
    logic [31:0] m_chunk_kind_word;
    logic [31:0] m_chunk_data_start;
    logic [31:0] m_chunk_size;
    logic        m_chunk_is_binary;
    logic        m_object_done;
    logic [2:0]  m_status_code;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // Register copies
    logic [31:0] cfg_version;
    logic [31:0] cfg_json;
    logic [31:0] cfg_binary;

    // Object state of the predictor
    logic [31:0] seen_bytes;
    logic [31:0] lane_shift;
    logic        magic_ok;
    logic [31:0] hdr_version;
    logic [31:0] hdr_length;
    walk_t       walk;
    logic [31:0] chunk_len;
    logic [31:0] data_left;
    logic        have_json;
    logic        have_binary;
    status_t     chunk_err;
    logic [3:0]  hdr_pos;
    logic [31:0] type_acc;

    result_t     expected_reports[$];
    logic [7:0]  obj_bytes[$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    bit          idle_en = 1'b0;

    glb_container_checker u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_last_byte        (s_last_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_chunk_valid      (m_chunk_valid),
        .m_chunk_kind_word  (m_chunk_kind_word),
        .m_chunk_data_start (m_chunk_data_start),
        .m_chunk_size       (m_chunk_size),
        .m_chunk_is_binary  (m_chunk_is_binary),
        .m_object_done      (m_object_done),
        .m_status_code      (m_status_code),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_object_state();
        seen_bytes  = '0;
        lane_shift  = '0;
        magic_ok    = 1'b1;
        hdr_version = '0;
        hdr_length  = '0;
        walk        = WALK_HEADER;
        chunk_len   = '0;
        data_left   = '0;
        have_json   = 1'b0;
        have_binary = 1'b0;
        chunk_err   = ST_OK;
        hdr_pos     = '0;
        type_acc    = '0;
    endfunction

    // Work out the report for one accepted byte, if any, and queue it
    task automatic predict_glb_byte(input logic [7:0] b, input logic last);
        logic [31:0] pos;
        logic [31:0] lane;
        logic        hit;
        logic        is_bin;
        status_t     err;
        status_t     st;
        result_t     r;
        pos    = seen_bytes;
        lane   = lane_shift & 32'd24;
        hit    = 1'b0;
        is_bin = 1'b0;
        err    = ST_OK;
        r      = '0;

        if (pos < 32'd4) begin
            if (b != GLB_MAGIC_LE[8 * pos[1:0] +: 8]) magic_ok = 1'b0;
        end else if (pos < 32'd8) begin
            hdr_version |= 32'(b) << lane;
        end else if (pos < 32'd12) begin
            hdr_length |= 32'(b) << lane;
        end else if (magic_ok && hdr_version == cfg_version && chunk_err == ST_OK &&
                     walk != WALK_STOP && pos < hdr_length) begin
            if (walk == WALK_DATA) begin
                data_left--;
                if (data_left == 0) begin
                    walk    = WALK_HEADER;
                    hdr_pos = '0;
                end
            end else if (hdr_pos == 0 && {1'b0, pos} + 33'd8 > {1'b0, hdr_length}) begin
                // chunk header would run past the declared end
                chunk_err = ST_SHORT;
                walk      = WALK_STOP;
            end else begin
                if (hdr_pos == 0) begin
                    chunk_len = '0;
                    type_acc  = '0;
                end
                if (hdr_pos < 4) chunk_len |= 32'(b) << lane;
                else type_acc |= 32'(b) << lane;
                hdr_pos++;
                if (hdr_pos >= 8) begin
                    hdr_pos = '0;
                    if (chunk_len[1:0] != 2'd0) err = ST_ALIGN;
                    else if ({1'b0, pos} + 33'd1 + {1'b0, chunk_len} > {1'b0, hdr_length})
                        err = ST_SHORT;
                    else if (!have_json) begin
                        if (type_acc != cfg_json) err = ST_ORDER;
                        else have_json = 1'b1;
                    end else if (type_acc == cfg_binary && !have_binary) begin
                        have_binary = 1'b1;
                        is_bin      = 1'b1;
                    end else err = ST_UNSUPPORTED;

                    if (err != ST_OK) begin
                        chunk_err = err;
                        walk      = WALK_STOP;
                    end else begin
                        hit                = 1'b1;
                        r.chunk_valid      = 1'b1;
                        r.chunk_kind_word  = type_acc;
                        r.chunk_data_start = pos + 32'd1;
                        r.chunk_size       = chunk_len;
                        r.chunk_is_binary  = is_bin;
                        if (chunk_len != 0) begin
                            walk      = WALK_DATA;
                            data_left = chunk_len;
                        end
                    end
                end
            end
        end

        if (seen_bytes != 32'hFFFF_FFFF) seen_bytes++;
        lane_shift = (lane_shift + 32'd8) & 32'd31;

        // Final status follows the header checks first, then the chunk walk
        if (last) begin
            if ({1'b0, pos} + 33'd1 < 33'd12) st = ST_SHORT;
            else if (!magic_ok) st = ST_BAD_MAGIC;
            else if (hdr_version != cfg_version) st = ST_VERSION;
            else if ({1'b0, pos} + 33'd1 != {1'b0, hdr_length}) st = ST_LEN_MISM;
            else if (chunk_err != ST_OK) st = chunk_err;
            else if (!have_json) st = ST_ORDER;
            else st = ST_OK;
            r.object_done = 1'b1;
            r.status_code = st;
            clear_object_state();
        end

        if (hit || last) expected_reports = {expected_reports, r};
    endtask

    // ------------------------------------------------------------------
    // Result checking and back-pressure
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("report with none expected");
            end else begin
                want = expected_reports.pop_front();
                check_field("chunk_valid", 32'(m_chunk_valid), 32'(want.chunk_valid));
                check_field("chunk_kind_word", m_chunk_kind_word, want.chunk_kind_word);
                check_field("chunk_data_start", m_chunk_data_start, want.chunk_data_start);
                check_field("chunk_size", m_chunk_size, want.chunk_size);
                check_field("chunk_is_binary", 32'(m_chunk_is_binary),
                            32'(want.chunk_is_binary));
                check_field("object_done", 32'(m_object_done), 32'(want.object_done));
                check_field("status_code", 32'(m_status_code), 32'(want.status_code));
            end
        end
    end

    // With idle_en set, stall the result side for a random spell after each request
    initial begin
        int stall;
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready && idle_en) begin
                stall = $urandom_range(0, 15);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        gap = idle_en ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= value;
        s_last_byte <= is_last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        predict_glb_byte(value, is_last);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_register(input cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_VERSION: cfg_version = value;
            CFG_JSON:    cfg_json    = value;
            CFG_BINARY:  cfg_binary  = value;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [31:0] ver, input logic [31:0] json_code,
                               input logic [31:0] bin_code);
        write_register(CFG_VERSION, ver);
        write_register(CFG_JSON, json_code);
        write_register(CFG_BINARY, bin_code);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, let outstanding reports drain, then settle
    task automatic wait_idle();
        int i;
        s_valid <= 1'b0;
        for (i = 0; i < 1000 && expected_reports.size() != 0; i++) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (expected_reports.size() != 0) begin
            report_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
            expected_reports.delete();
        end
    endtask

    // ------------------------------------------------------------------
    // Object construction
    // ------------------------------------------------------------------
    function automatic void push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) obj_bytes = {obj_bytes, w[8 * i +: 8]};
    endfunction

    function automatic void push_fill(input int n);
        for (int i = 0; i < n; i++) obj_bytes = {obj_bytes, 8'($urandom)};
    endfunction

    task automatic run_object();
        int n;
        n = obj_bytes.size();
        for (int i = 0; i < n; i++) send_byte(obj_bytes[i], i == n - 1);
    endtask

    // Build a mostly well-formed object, broken in the way the shape asks
    function automatic void build_object(input shape_t shape);
        logic [31:0] json_len;
        logic [31:0] bin_len;
        logic [31:0] clen;
        logic [31:0] ver;
        logic [31:0] jtype;
        logic [31:0] declared;
        bit          with_bin;
        int          k;
        obj_bytes.delete();
        if (shape == OBJ_NOISE) begin
            push_fill($urandom_range(1, 40));
            return;
        end
        json_len = 32'(4 * $urandom_range(0, 6));
        if ($urandom_range(0, 15) == 0) json_len = 32'(4 * $urandom_range(7, 40));
        bin_len  = 32'(4 * $urandom_range(0, 6));
        with_bin = $urandom_range(0, 1) || shape == OBJ_TWO_BINARY;
        ver      = cfg_version;
        jtype    = cfg_json;
        if (shape == OBJ_BAD_VERSION) ver = cfg_version ^ (32'd1 << $urandom_range(0, 31));
        if (shape == OBJ_NOT_JSON) jtype = $urandom_range(0, 1) ? cfg_binary : $urandom;

        push_word(GLB_MAGIC_LE);
        push_word(ver);
        push_word(32'd0);
        if (shape != OBJ_HDR_ONLY) begin
            clen = json_len;
            if (shape == OBJ_MISALIGNED) clen = json_len + 32'($urandom_range(1, 3));
            if (shape == OBJ_OVERRUN)
                clen = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFC
                                                  : json_len + 32'(4 * $urandom_range(1, 4));
            push_word(clen);
            push_word(jtype);
            push_fill(int'(json_len));
            if (with_bin) begin
                push_word(bin_len);
                push_word(cfg_binary);
                push_fill(int'(bin_len));
            end
            if (shape == OBJ_TWO_BINARY) begin
                push_word(32'd4);
                push_word(cfg_binary);
                push_fill(4);
            end
            if (shape == OBJ_BAD_SECOND) begin
                push_word(32'd8);
                push_word($urandom);
                push_fill(8);
            end
            // leave too few bytes for another chunk header
            if (shape == OBJ_CROSSING) push_fill($urandom_range(1, 7));
        end

        declared = 32'(obj_bytes.size());
        if (shape == OBJ_LEN_OFF) begin
            k = $urandom_range(0, 3);
            if (k == 0) declared = $urandom;
            else if (k == 1) declared = declared + 32'($urandom_range(1, 8));
            else declared = declared - 32'($urandom_range(1, 8));
        end
        for (int i = 0; i < 4; i++) obj_bytes[8 + i] = declared[8 * i +: 8];

        if (shape == OBJ_BAD_MAGIC)
            obj_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        if (shape == OBJ_TRUNCATED)
            repeat ($urandom_range(1, 8)) void'(obj_bytes.pop_back());
        if (shape == OBJ_TRAILING) push_fill($urandom_range(1, 12));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short object with extreme byte values, header with no chunk, smallest good object
    task automatic test_directed_objects();
        idle_en = 1'b0;
        obj_bytes = '{8'h00, 8'hFF, 8'h67};
        run_object();

        obj_bytes.delete();
        push_word(GLB_MAGIC_LE);
        push_word(cfg_version);
        push_word(32'd12);
        run_object();

        obj_bytes.delete();
        push_word(GLB_MAGIC_LE);
        push_word(cfg_version);
        push_word(32'd20);
        push_word(32'd0);
        push_word(cfg_json);
        run_object();
        wait_idle();
    endtask

    // Optional sweep through every shape, then a random mix up to the byte budget
    task automatic test_mixed_objects(input int budget, input bit sweep);
        int     start;
        int     r;
        shape_t shape;
        start = bytes_sent;
        if (sweep) begin
            for (int s = OBJ_VALID; s <= OBJ_NOISE; s++) begin
                idle_en = $urandom_range(0, 3) != 0;
                build_object(shape_t'(s));
                run_object();
            end
        end
        while (bytes_sent - start < budget) begin
            idle_en = $urandom_range(0, 3) != 0;
            r = $urandom_range(0, 25);
            shape = (r < 13) ? shape_t'(r + 1) : OBJ_VALID;
            build_object(shape);
            run_object();
        end
        wait_idle();
    endtask

    task automatic test_config_extremes();
        load_config(32'd0, 32'd0, 32'hFFFF_FFFF);
        test_mixed_objects(250, 1'b0);
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        test_mixed_objects(150, 1'b0);
    endtask

    // JSON and binary share one type word
    task automatic test_shared_type_code();
        logic [31:0] code;
        code = $urandom;
        load_config(32'($urandom_range(0, 3)), code, code);
        test_mixed_objects(150, 1'b0);
    endtask

    task automatic test_random_config();
        load_config($urandom, $urandom, $urandom);
        test_mixed_objects(200, 1'b0);
    endtask

    task automatic test_default_restore();
        load_config(VERSION_RST, JSON_TYPE_RST, BINARY_TYPE_RST);
        test_mixed_objects(100, 1'b0);
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data_byte <= '0;
        s_last_byte <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_VERSION;
        cfg_data    <= '0;
        cfg_version  = VERSION_RST;
        cfg_json     = JSON_TYPE_RST;
        cfg_binary   = BINARY_TYPE_RST;
        clear_object_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_objects();
        test_mixed_objects(450, 1'b1);
        test_config_extremes();
        test_shared_type_code();
        test_random_config();
        test_default_restore();

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
